### rtl/lidar_sector_obstacle_guard_core_defines.svh
// Assertion macros for the lidar sector obstacle guard.
// Both assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef LIDAR_SECTOR_OBSTACLE_GUARD_CORE_DEFINES_SVH
`define LIDAR_SECTOR_OBSTACLE_GUARD_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LSOG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lsog assertion failed");
`define LSOG_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lsog forbidden condition seen");
`else
`define LSOG_ASSERT(lbl, prop)
`define LSOG_ASSERT_NEVER(lbl, expr)
`endif

`endif

### rtl/lsog_pkg.sv
package lsog_pkg;

    localparam int RANGE_W    = 16;
    localparam int ANGLE_W    = 24;
    localparam int STEP_W     = 18;
    localparam int HALF_W     = 22;
    localparam int TICK_W     = 20;
    localparam int WIDE_W     = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Two-entry queues on both sides of the back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RANGE_W-1:0]        NONE_MM          = '1;
    localparam logic [TICK_W-1:0]         TICK_MAX         = '1;
    localparam logic signed [WIDE_W-1:0]  PI_URAD          = 26'sd3141593;
    localparam logic signed [ANGLE_W-1:0] ANGLE_CEIL       = 24'sh7FFFFF;
    localparam logic signed [ANGLE_W-1:0] ANGLE_FLOOR      = 24'sh800000;
    localparam logic                      SIDE_FROM_MINIMA = 1'b1;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_GOAL   = 2'd2,
        CMD_DONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_STOP    = 2'd1,
        ACT_REROUTE = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_START  = 3'd0,
        REG_ANGLE_STEP   = 3'd1,
        REG_HALF_WIDTH   = 3'd2,
        REG_CRITICAL     = 3'd3,
        REG_OBSTACLE     = 3'd4,
        REG_RANGE_LOWER  = 3'd5,
        REG_RANGE_UPPER  = 3'd6,
        REG_COOLDOWN     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_start;
        logic signed [STEP_W-1:0]  angle_step;
        logic [HALF_W-1:0]         sector_half_width;
        logic [RANGE_W-1:0]        stop_dist_mm;
        logic [RANGE_W-1:0]        reroute_dist_mm;
        logic [RANGE_W-1:0]        range_lower;
        logic [RANGE_W-1:0]        range_upper;
        logic [TICK_W-1:0]         cooldown_ticks;
    } cfg_t;

    // Classified transaction handed from front end to back end
    typedef struct packed {
        cmd_t               cmd;
        logic [RANGE_W-1:0] range_mm;
        logic               hit;
        logic               left;
        logic               last;
        logic               reroute_ok;
    } op_t;

    typedef struct packed {
        action_t            action;
        logic               reroute_left;
        logic [RANGE_W-1:0] nearest_left;
        logic [RANGE_W-1:0] nearest_right;
    } result_t;

endpackage

### rtl/lsog_front.sv
module lsog_front (
    input  logic               clk,
    input  logic               rst_n,
    input  lsog_pkg::cfg_t     cfg,
    input  logic               in_valid,
    input  logic [1:0]         cmd,
    input  logic [15:0]        range_mm,
    input  logic               range_finite,
    input  logic               last_sample,
    input  logic               reroute_ok,
    output lsog_pkg::op_t      op
);
    import lsog_pkg::*;

    logic                      scan_open_reg;
    logic                      scan_open_next;
    logic signed [ANGLE_W-1:0] sample_angle_reg;
    logic signed [ANGLE_W-1:0] sample_angle_next;
    logic signed [ANGLE_W-1:0] ang;
    logic signed [ANGLE_W:0]   ang_sum;
    logic signed [ANGLE_W-1:0] ang_sat;
    logic signed [WIDE_W-1:0]  ang_wide;
    logic signed [WIDE_W-1:0]  half_wide;
    logic signed [WIDE_W-1:0]  sector_lo;
    logic signed [WIDE_W-1:0]  sector_hi;
    logic                      is_sample;
    logic                      in_sector;
    logic                      in_range;

    // Running angle of the current sample, saturated at the 24-bit limits
    always_comb
    begin
        is_sample = (cmd_t'(cmd) == CMD_SAMPLE);
        ang       = scan_open_reg ? sample_angle_reg : cfg.angle_start;
        ang_sum   = {ang[ANGLE_W-1], ang}
                  + {{(ANGLE_W + 1 - STEP_W){cfg.angle_step[STEP_W-1]}}, cfg.angle_step};
        if (ang_sum[ANGLE_W] != ang_sum[ANGLE_W-1])
        begin
            ang_sat = ang_sum[ANGLE_W] ? ANGLE_FLOOR : ANGLE_CEIL;
        end
        else
        begin
            ang_sat = ang_sum[ANGLE_W-1:0];
        end
    end

    // Sector window around pi and range window
    always_comb
    begin
        ang_wide  = {{(WIDE_W - ANGLE_W){ang[ANGLE_W-1]}}, ang};
        half_wide = $signed({{(WIDE_W - HALF_W){1'b0}}, cfg.sector_half_width});
        sector_lo = PI_URAD - half_wide;
        sector_hi = PI_URAD + half_wide;
        in_sector = (ang_wide >= sector_lo) && (ang_wide <= sector_hi);
        in_range  = range_finite && (range_mm >= cfg.range_lower)
                    && (range_mm <= cfg.range_upper);
    end

    // Classified transaction
    always_comb
    begin
        op.cmd        = cmd_t'(cmd);
        op.range_mm   = range_mm;
        op.hit        = is_sample && in_sector && in_range;
        op.left       = ang_wide > PI_URAD;
        op.last       = last_sample;
        op.reroute_ok = reroute_ok;
    end

    // Scan tracking: a last sample closes the scan
    always_comb
    begin
        scan_open_next    = scan_open_reg;
        sample_angle_next = sample_angle_reg;
        if (in_valid && is_sample)
        begin
            if (last_sample)
            begin
                scan_open_next    = 1'b0;
                sample_angle_next = cfg.angle_start;
            end
            else
            begin
                scan_open_next    = 1'b1;
                sample_angle_next = ang_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_open_reg    <= 1'b0;
            sample_angle_reg <= '0;
        end
        else
        begin
            scan_open_reg    <= scan_open_next;
            sample_angle_reg <= sample_angle_next;
        end
    end

endmodule

### rtl/lsog_queue.sv
module lsog_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lsog_pkg::op_t push_data,
    output logic          full,
    input  logic          pop,
    output lsog_pkg::op_t pop_data,
    output logic          empty
);
    import lsog_pkg::*;

    op_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/lsog_back.sv
`include "lidar_sector_obstacle_guard_core_defines.svh"

module lsog_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lsog_pkg::cfg_t    cfg,
    input  logic              op_valid,
    input  lsog_pkg::op_t     op,
    output logic              op_pop,
    input  logic              res_pop,
    output lsog_pkg::result_t res,
    output logic              res_empty
);
    import lsog_pkg::*;

    logic               goal_active_reg,   goal_active_next;
    logic               obstacle_flag_reg, obstacle_flag_next;
    logic               reroute_busy_reg,  reroute_busy_next;
    logic [TICK_W-1:0]  since_reroute_reg, since_reroute_next;
    logic [RANGE_W-1:0] left_min_reg,      left_min_next;
    logic [RANGE_W-1:0] right_min_reg,     right_min_next;

    result_t            out_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  out_wr_ptr_reg, out_wr_ptr_next;
    logic [QPTR_W-1:0]  out_rd_ptr_reg, out_rd_ptr_next;
    logic [QCNT_W-1:0]  out_cnt_reg,    out_cnt_next;

    logic               take;
    logic               out_wr;
    result_t            out_wr_data;
    logic               out_rd;
    logic [RANGE_W-1:0] nl;
    logic [RANGE_W-1:0] nr;
    logic [RANGE_W-1:0] front;
    logic               reroute_wr;
    logic               flag_wr;

    // Consume a transaction whenever the result queue has a free slot
    assign take      = op_valid && (out_cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign op_pop    = take;
    assign res_empty = (out_cnt_reg == '0);
    assign res       = out_mem[out_rd_ptr_reg];
    assign out_rd    = res_pop && !res_empty;

    // Sector minima including the current sample
    always_comb
    begin
        nl = left_min_reg;
        nr = right_min_reg;
        if (op.hit && op.left && (op.range_mm < left_min_reg))
        begin
            nl = op.range_mm;
        end
        if (op.hit && !op.left && (op.range_mm < right_min_reg))
        begin
            nr = op.range_mm;
        end
        front = (nl < nr) ? nl : nr;
    end

    // Command execution and end-of-scan decision
    always_comb
    begin
        goal_active_next   = goal_active_reg;
        obstacle_flag_next = obstacle_flag_reg;
        reroute_busy_next  = reroute_busy_reg;
        since_reroute_next = since_reroute_reg;
        left_min_next      = left_min_reg;
        right_min_next     = right_min_reg;
        out_wr             = 1'b0;
        out_wr_data.action        = ACT_NONE;
        out_wr_data.reroute_left  = 1'b0;
        out_wr_data.nearest_left  = nl;
        out_wr_data.nearest_right = nr;
        if (take)
        begin
            case (op.cmd)
                CMD_TICK:
                begin
                    if (since_reroute_reg != TICK_MAX)
                    begin
                        since_reroute_next = since_reroute_reg + 1'b1;
                    end
                end
                CMD_GOAL:
                begin
                    goal_active_next = 1'b1;
                end
                CMD_DONE:
                begin
                    if (reroute_busy_reg)
                    begin
                        reroute_busy_next  = 1'b0;
                        since_reroute_next = '0;
                        if (op.reroute_ok)
                        begin
                            out_wr                    = 1'b1;
                            out_wr_data.action        = ACT_CLEAR;
                            out_wr_data.nearest_left  = NONE_MM;
                            out_wr_data.nearest_right = NONE_MM;
                        end
                    end
                end
                CMD_SAMPLE:
                begin
                    if (!op.last)
                    begin
                        left_min_next  = nl;
                        right_min_next = nr;
                    end
                    else
                    begin
                        out_wr         = 1'b1;
                        left_min_next  = NONE_MM;
                        right_min_next = NONE_MM;
                        if (goal_active_reg)
                        begin
                            if (front < cfg.stop_dist_mm)
                            begin
                                if (!obstacle_flag_reg)
                                begin
                                    out_wr_data.action = ACT_STOP;
                                    obstacle_flag_next = 1'b1;
                                end
                            end
                            else if (front < cfg.reroute_dist_mm)
                            begin
                                if (!reroute_busy_reg
                                    && (since_reroute_reg >= cfg.cooldown_ticks))
                                begin
                                    out_wr_data.action       = ACT_REROUTE;
                                    out_wr_data.reroute_left =
                                        SIDE_FROM_MINIMA ? (nl < nr) : 1'b1;
                                    reroute_busy_next        = 1'b1;
                                    obstacle_flag_next       = 1'b1;
                                end
                            end
                            else if (obstacle_flag_reg)
                            begin
                                out_wr_data.action = ACT_CLEAR;
                                obstacle_flag_next = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result queue pointers and fill count
    always_comb
    begin
        out_wr_ptr_next = out_wr_ptr_reg;
        out_rd_ptr_next = out_rd_ptr_reg;
        out_cnt_next    = out_cnt_reg;
        if (out_wr)
        begin
            out_wr_ptr_next = (out_wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : out_wr_ptr_reg + 1'b1;
        end
        if (out_rd)
        begin
            out_rd_ptr_next = (out_rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : out_rd_ptr_reg + 1'b1;
        end
        if (out_wr && !out_rd)
        begin
            out_cnt_next = out_cnt_reg + 1'b1;
        end
        else if (out_rd && !out_wr)
        begin
            out_cnt_next = out_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_active_reg   <= 1'b0;
            obstacle_flag_reg <= 1'b0;
            reroute_busy_reg  <= 1'b0;
            since_reroute_reg <= '0;
            left_min_reg      <= NONE_MM;
            right_min_reg     <= NONE_MM;
            out_wr_ptr_reg    <= '0;
            out_rd_ptr_reg    <= '0;
            out_cnt_reg       <= '0;
        end
        else
        begin
            goal_active_reg   <= goal_active_next;
            obstacle_flag_reg <= obstacle_flag_next;
            reroute_busy_reg  <= reroute_busy_next;
            since_reroute_reg <= since_reroute_next;
            left_min_reg      <= left_min_next;
            right_min_reg     <= right_min_next;
            out_wr_ptr_reg    <= out_wr_ptr_next;
            out_rd_ptr_reg    <= out_rd_ptr_next;
            out_cnt_reg       <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr)
        begin
            out_mem[out_wr_ptr_reg] <= out_wr_data;
        end
    end

    // Result writes that start a reroute or raise the obstacle flag
    assign reroute_wr = out_wr && (out_wr_data.action == ACT_REROUTE);
    assign flag_wr    = out_wr && (out_wr_data.action inside {ACT_STOP, ACT_REROUTE});

    // A reroute starts only together with a reroute result
    `LSOG_ASSERT(a_busy_rise, $rose(reroute_busy_reg) |-> $past(reroute_wr))
    // Ending a reroute restarts the cooldown
    `LSOG_ASSERT(a_busy_fall, $fell(reroute_busy_reg) |-> (since_reroute_reg == '0))
    // Obstacle flag is raised only by a stop or a reroute result
    `LSOG_ASSERT(a_flag_rise, $rose(obstacle_flag_reg) |-> $past(flag_wr))
    // Side bit only accompanies a reroute
    `LSOG_ASSERT_NEVER(a_side_only_reroute, out_wr && out_wr_data.reroute_left && !reroute_wr)

endmodule

### rtl/lidar_sector_obstacle_guard_core.sv
// Lidar sector obstacle guard: range samples, time ticks, goal-set and reroute-done
// transactions enter through push/full at up to one per clock; every last sample of
// a scan yields one result (action, reroute side, left and right sector minima),
// and a successful reroute-done yields a clear-stop result. A transaction is
// classified in the front end (running angle, sector and range windows) as it is
// accepted, waits in a two-entry hand-off queue, and is executed by the back end,
// which writes its result into a two-entry result queue; with both queues free a
// result is visible (empty low) as soon as the back end has moved it from the
// hand-off queue into the result queue. Throughput is one transaction per cycle as
// long as results are popped; a stalled result side fills both queues and then
// raises full. Configuration writes take effect at the next clock edge and must be
// made while the block is idle. No clearing pass follows reset.
module lidar_sector_obstacle_guard_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lsog_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsog_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          cmd,
    input  logic [15:0]                         range_mm,
    input  logic                                range_finite,
    input  logic                                last_sample,
    input  logic                                reroute_ok,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          action,
    output logic                                reroute_left,
    output logic [15:0]                         nearest_left,
    output logic [15:0]                         nearest_right
);
    import lsog_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    op_t     front_op;
    op_t     mid_op;
    logic    in_valid;
    logic    mid_empty;
    logic    mid_pop;
    result_t res;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ANGLE_START: cfg_next.angle_start       = cfg_data[ANGLE_W-1:0];
                REG_ANGLE_STEP:  cfg_next.angle_step        = cfg_data[STEP_W-1:0];
                REG_HALF_WIDTH:  cfg_next.sector_half_width = cfg_data[HALF_W-1:0];
                REG_CRITICAL:    cfg_next.stop_dist_mm      = cfg_data[RANGE_W-1:0];
                REG_OBSTACLE:    cfg_next.reroute_dist_mm   = cfg_data[RANGE_W-1:0];
                REG_RANGE_LOWER: cfg_next.range_lower       = cfg_data[RANGE_W-1:0];
                REG_RANGE_UPPER: cfg_next.range_upper       = cfg_data[RANGE_W-1:0];
                REG_COOLDOWN:    cfg_next.cooldown_ticks    = cfg_data[TICK_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_start       <= '0;
            cfg_reg.angle_step        <= 18'sd17453;
            cfg_reg.sector_half_width <= 22'd523599;
            cfg_reg.stop_dist_mm      <= 16'd500;
            cfg_reg.reroute_dist_mm   <= 16'd600;
            cfg_reg.range_lower       <= 16'd120;
            cfg_reg.range_upper       <= 16'd12000;
            cfg_reg.cooldown_ticks    <= 20'd3000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_valid = push && !full;

    lsog_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .cmd          (cmd),
        .range_mm     (range_mm),
        .range_finite (range_finite),
        .last_sample  (last_sample),
        .reroute_ok   (reroute_ok),
        .op           (front_op)
    );

    lsog_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_op),
        .full      (full),
        .pop       (mid_pop),
        .pop_data  (mid_op),
        .empty     (mid_empty)
    );

    lsog_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .op_valid  (!mid_empty),
        .op        (mid_op),
        .op_pop    (mid_pop),
        .res_pop   (pop),
        .res       (res),
        .res_empty (empty)
    );

    assign action        = res.action;
    assign reroute_left  = res.reroute_left;
    assign nearest_left  = res.nearest_left;
    assign nearest_right = res.nearest_right;

endmodule

### bench/lidar_sector_obstacle_guard_scoreboard_pkg.sv
`timescale 1ns / 1ps
package guard_check_pkg;
    import lsog_pkg::*;

    // Predicts guard actions from accepted transactions and checks popped results
    class guard_action_scoreboard;
        cfg_t cfg;

        // Guard state, tracked transaction by transaction
        bit goal_active;
        bit obstacle_flag;
        bit reroute_busy;
        bit scan_open;
        logic [TICK_W-1:0] since_reroute;
        logic signed [ANGLE_W-1:0] scan_angle;
        logic [RANGE_W-1:0] left_min;
        logic [RANGE_W-1:0] right_min;

        result_t expected_actions[$];
        int mismatches;
        int results_checked;
        int action_seen[4];

        function new();
            cfg.angle_start = 0;
            cfg.angle_step = 17453;
            cfg.sector_half_width = 523599;
            cfg.stop_dist_mm = 500;
            cfg.reroute_dist_mm = 600;
            cfg.range_lower = 120;
            cfg.range_upper = 12000;
            cfg.cooldown_ticks = 3000;
            goal_active = 1'b0;
            obstacle_flag = 1'b0;
            reroute_busy = 1'b0;
            scan_open = 1'b0;
            since_reroute = '0;
            scan_angle = '0;
            left_min = NONE_MM;
            right_min = NONE_MM;
            mismatches = 0;
            results_checked = 0;
            foreach (action_seen[i]) action_seen[i] = 0;
        endfunction

        function void set_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ANGLE_START: cfg.angle_start = data[ANGLE_W-1:0];
                REG_ANGLE_STEP:  cfg.angle_step = data[STEP_W-1:0];
                REG_HALF_WIDTH:  cfg.sector_half_width = data[HALF_W-1:0];
                REG_CRITICAL:    cfg.stop_dist_mm = data[RANGE_W-1:0];
                REG_OBSTACLE:    cfg.reroute_dist_mm = data[RANGE_W-1:0];
                REG_RANGE_LOWER: cfg.range_lower = data[RANGE_W-1:0];
                REG_RANGE_UPPER: cfg.range_upper = data[RANGE_W-1:0];
                REG_COOLDOWN:    cfg.cooldown_ticks = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_actions.size();
        endfunction

        // Returns 0 when the transaction is ignored by the block
        function bit note_item(cmd_t cmd, logic [RANGE_W-1:0] range_mm, bit finite,
                               bit is_last, bit ok);
            longint ang;
            longint nxt;
            longint lo;
            longint hi;
            logic [RANGE_W-1:0] front;
            result_t res;

            case (cmd)
                CMD_TICK: begin
                    if (since_reroute != TICK_MAX) since_reroute++;
                    return 1'b1;
                end
                CMD_GOAL: begin
                    goal_active = 1'b1;
                    return 1'b1;
                end
                CMD_DONE: begin
                    if (!reroute_busy) return 1'b0;
                    reroute_busy = 1'b0;
                    since_reroute = '0;
                    if (ok) begin
                        res.action = ACT_CLEAR;
                        res.reroute_left = 1'b0;
                        res.nearest_left = NONE_MM;
                        res.nearest_right = NONE_MM;
                        expected_actions.insert(expected_actions.size(), res);
                    end
                    return 1'b1;
                end
                default: ;
            endcase

            // Running angle, saturating at the 24-bit signed limits
            ang = scan_open ? longint'($signed(scan_angle)) : longint'($signed(cfg.angle_start));
            nxt = ang + longint'($signed(cfg.angle_step));
            if (nxt > longint'(ANGLE_CEIL)) nxt = longint'(ANGLE_CEIL);
            if (nxt < longint'(ANGLE_FLOOR)) nxt = longint'(ANGLE_FLOOR);
            scan_angle = ANGLE_W'(nxt);
            scan_open = 1'b1;

            // Sector and range window
            lo = longint'(PI_URAD) - longint'(cfg.sector_half_width);
            hi = longint'(PI_URAD) + longint'(cfg.sector_half_width);
            if (ang >= lo && ang <= hi && finite &&
                range_mm >= cfg.range_lower && range_mm <= cfg.range_upper) begin
                if (ang > longint'(PI_URAD)) begin
                    if (range_mm < left_min) left_min = range_mm;
                end
                else if (range_mm < right_min) right_min = range_mm;
            end

            if (!is_last) return 1'b1;

            // End of scan: decide the action
            front = (left_min < right_min) ? left_min : right_min;
            res.action = ACT_NONE;
            res.reroute_left = 1'b0;
            res.nearest_left = left_min;
            res.nearest_right = right_min;
            if (goal_active) begin
                if (front < cfg.stop_dist_mm) begin
                    if (!obstacle_flag) begin
                        res.action = ACT_STOP;
                        obstacle_flag = 1'b1;
                    end
                end
                else if (front < cfg.reroute_dist_mm) begin
                    if (!reroute_busy && since_reroute >= cfg.cooldown_ticks) begin
                        res.action = ACT_REROUTE;
                        reroute_busy = 1'b1;
                        obstacle_flag = 1'b1;
                        res.reroute_left = SIDE_FROM_MINIMA ? (left_min < right_min) : 1'b1;
                    end
                end
                else if (obstacle_flag) begin
                    res.action = ACT_CLEAR;
                    obstacle_flag = 1'b0;
                end
            end
            expected_actions.insert(expected_actions.size(), res);
            left_min = NONE_MM;
            right_min = NONE_MM;
            scan_open = 1'b0;
            scan_angle = cfg.angle_start;
            return 1'b1;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_actions.size() == 0) begin
                $error("result with nothing expected: action %0d left %0d nearest %0d/%0d",
                       got.action, got.reroute_left, got.nearest_left, got.nearest_right);
                mismatches++;
                return;
            end
            want = expected_actions.pop_front();
            results_checked++;
            action_seen[int'(want.action)]++;
            if (got.action !== want.action) begin
                $error("action: expected %0d, actual %0d", want.action, got.action);
                mismatches++;
            end
            if (got.reroute_left !== want.reroute_left) begin
                $error("reroute_left: expected %0d, actual %0d",
                       want.reroute_left, got.reroute_left);
                mismatches++;
            end
            if (got.nearest_left !== want.nearest_left) begin
                $error("nearest_left: expected %0d, actual %0d",
                       want.nearest_left, got.nearest_left);
                mismatches++;
            end
            if (got.nearest_right !== want.nearest_right) begin
                $error("nearest_right: expected %0d, actual %0d",
                       want.nearest_right, got.nearest_right);
                mismatches++;
            end
        endfunction
    endclass

endpackage

### bench/lidar_sector_obstacle_guard_core_test.sv
`timescale 1ns / 1ps
module lidar_sector_obstacle_guard_core_test;
    import lsog_pkg::*;
    import guard_check_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic push = 1'b0;
    logic full;
    logic [1:0] cmd = CMD_SAMPLE;
    logic [15:0] range_mm = '0;
    logic range_finite = 1'b0;
    logic last_sample = 1'b0;
    logic reroute_ok = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [1:0] action;
    logic reroute_left;
    logic [15:0] nearest_left;
    logic [15:0] nearest_right;

    guard_action_scoreboard board;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int items_counted = 0;
    int quiet_cycles = 0;

    lidar_sector_obstacle_guard_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .cmd(cmd),
        .range_mm(range_mm),
        .range_finite(range_finite),
        .last_sample(last_sample),
        .reroute_ok(reroute_ok),
        .empty(empty),
        .pop(pop),
        .action(action),
        .reroute_left(reroute_left),
        .nearest_left(nearest_left),
        .nearest_right(nearest_right)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left = hold_left - 1;
            if (hold_left == 0) holds_served = holds_served + 1;
        end
        else if (holds_served != hold_requests)
        begin
            pop <= 1'b0;
            hold_left = HOLD_CYCLES;
        end
        else
            pop <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && pop && !empty)
        begin
            got.action = action_t'(action);
            got.reroute_left = reroute_left;
            got.nearest_left = nearest_left;
            got.nearest_right = nearest_right;
            board.check_result(got);
        end
    end

    // Watchdog: ends the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(cmd_t c, logic [15:0] r, bit fin, bit is_last, bit ok);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        cmd <= c;
        range_mm <= r;
        range_finite <= fin;
        last_sample <= is_last;
        reroute_ok <= ok;
        @(posedge clk);
        while (full !== 1'b0) @(posedge clk);
        if (board.note_item(c, r, fin, is_last, ok)) items_counted++;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        board.set_register(idx, value);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_config(cfg_t c);
        write_reg(REG_ANGLE_START, CFG_DATA_W'(c.angle_start));
        write_reg(REG_ANGLE_STEP, CFG_DATA_W'(c.angle_step));
        write_reg(REG_HALF_WIDTH, CFG_DATA_W'(c.sector_half_width));
        write_reg(REG_CRITICAL, CFG_DATA_W'(c.stop_dist_mm));
        write_reg(REG_OBSTACLE, CFG_DATA_W'(c.reroute_dist_mm));
        write_reg(REG_RANGE_LOWER, CFG_DATA_W'(c.range_lower));
        write_reg(REG_RANGE_UPPER, CFG_DATA_W'(c.range_upper));
        write_reg(REG_COOLDOWN, CFG_DATA_W'(c.cooldown_ticks));
    endtask

    // Wait until every expected result is out and the pipeline has drained
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            1: begin send_idle_pct = 51; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 51; end
            3: begin send_idle_pct = 9; stall_pct = 9; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
        endcase
    endtask

    // Readings clustered around the current thresholds and window edges
    function automatic logic [15:0] pick_range();
        case ($urandom_range(9))
            0, 1: return 16'($urandom_range(board.cfg.stop_dist_mm));
            2, 3: return 16'($urandom_range(board.cfg.reroute_dist_mm,
                                            board.cfg.stop_dist_mm));
            4, 5, 6: return 16'($urandom_range(board.cfg.range_upper,
                                               board.cfg.reroute_dist_mm));
            7: return 16'($urandom_range(65535));
            8:
                case ($urandom_range(5))
                    0: return 16'd0;
                    1: return 16'hFFFF;
                    2: return board.cfg.range_lower;
                    3: return board.cfg.range_upper;
                    4: return board.cfg.range_lower - 16'd1;
                    default: return board.cfg.range_upper + 16'd1;
                endcase
            default: return 16'($urandom_range(board.cfg.range_upper, board.cfg.range_lower));
        endcase
    endfunction

    task automatic send_scan(int len);
        for (int k = 0; k < len; k++)
            send_item(CMD_SAMPLE, pick_range(), $urandom_range(15) != 0, k == len - 1,
                      1'($urandom_range(1)));
    endtask

    // Mostly whole scans with ticks and reroute events, some raw noise
    task automatic run_traffic(int quota, int max_scan);
        int stop_at;
        int roll;
        stop_at = items_counted + quota;
        while (items_counted < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
            begin
                repeat ($urandom_range(3))
                    send_item(CMD_TICK, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                send_scan($urandom_range(100) < 85 ? $urandom_range(12, 1)
                                                   : $urandom_range(max_scan, 1));
            end
            else if (roll < 66)
                send_item(CMD_GOAL, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (roll < 80)
                send_item(CMD_DONE, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), $urandom_range(3) != 0);
            else if (roll < 88)
                repeat ($urandom_range(20, 1))
                    send_item(CMD_TICK, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                send_item(cmd_t'($urandom_range(3)), 16'($urandom_range(65535)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
        end
    endtask

    task automatic run_phase(cfg_t c, int idle_mode, int quota, int max_scan, bit hold);
        settle();
        apply_config(c);
        set_idling(idle_mode);
        if (hold) hold_requests++;
        run_traffic(quota, max_scan);
    endtask

    initial
    begin
        cfg_t cfg_narrow;
        cfg_t cfg_pi_edge;
        cfg_t cfg_top;
        cfg_t cfg_bottom;
        cfg_t cfg_fixed_angle;
        cfg_t cfg_reverse;

        // start, step, half width, critical, obstacle, lower, upper, cooldown
        cfg_narrow      = '{2500000, 100000, 523599, 500, 900, 120, 12000, 3};
        cfg_pi_edge     = '{2641593, 100000, 400000, 400, 1200, 300, 5000, 2};
        cfg_top         = '{6283186, 100000, 3141593, 0, 65535, 0, 65535, 0};
        cfg_bottom      = '{-6283186, -100000, 0, 65535, 0, 65535, 0, 1000000};
        cfg_fixed_angle = '{3141594, 0, 1, 700, 800, 1, 65534, 1};
        cfg_reverse     = '{3000000, -37000, 200000, 1000, 2000, 900, 3000, 5};

        board = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration, no goal yet: angles fall outside the sector
        send_item(CMD_SAMPLE, 16'd100, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'd300, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'd300, 1'b1, 1'b1, 1'b0);
        send_item(CMD_DONE, 16'd0, 1'b0, 1'b0, 1'b1);

        settle();
        apply_config(cfg_narrow);
        send_item(CMD_GOAL, 16'd0, 1'b0, 1'b0, 1'b0);
        // Close obstacle on the right: stop
        send_item(CMD_SAMPLE, 16'd100, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'd450, 1'b1, 1'b1, 1'b0);
        // Still close with the flag already set: no action
        send_item(CMD_SAMPLE, 16'd800, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'd800, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'd300, 1'b1, 1'b1, 1'b0);
        // Nothing in the sector: clear stop
        send_item(CMD_SAMPLE, 16'd700, 1'b1, 1'b1, 1'b0);
        repeat (3) send_item(CMD_TICK, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        // Window edges, non-finite reading, then a near left hit: reroute left
        send_item(CMD_SAMPLE, 16'd0, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'd120, 1'b0, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'd12000, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'd12001, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'd119, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 16'd700, 1'b1, 1'b1, 1'b0);
        // Successful reroute done, then a second one that is ignored
        send_item(CMD_DONE, 16'd0, 1'b0, 1'b0, 1'b1);
        send_item(CMD_DONE, 16'd0, 1'b0, 1'b0, 1'b1);

        set_idling(0);
        run_traffic(300, 14);
        run_phase(cfg_pi_edge, 1, 300, 12, 1'b0);
        run_phase(cfg_top, 2, 300, 28, 1'b1);
        run_phase(cfg_bottom, 3, 200, 28, 1'b0);
        run_phase(cfg_fixed_angle, 0, 250, 10, 1'b0);
        run_phase(cfg_reverse, 2, 375, 16, 1'b0);

        settle();
        $display("Covered %0d transactions over six register settings and four idling modes",
                 items_counted);
        $display("Results checked: %0d (none %0d, stop %0d, reroute %0d, clear %0d)",
                 board.results_checked, board.action_seen[0], board.action_seen[1],
                 board.action_seen[2], board.action_seen[3]);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### lidar_sector_obstacle_guard_core.f
+incdir+rtl
rtl/lsog_pkg.sv
rtl/lsog_front.sv
rtl/lsog_queue.sv
rtl/lsog_back.sv
rtl/lidar_sector_obstacle_guard_core.sv
bench/lidar_sector_obstacle_guard_scoreboard_pkg.sv
bench/lidar_sector_obstacle_guard_core_test.sv
